// File: rtl/core/h3_settings_body_parser_core_defines.svh
// Assertion macros for the settings body parser core.
`ifndef H3_SETTINGS_BODY_PARSER_CORE_DEFINES_SVH
`define H3_SETTINGS_BODY_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, masked while reset is high.
`define H3SP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h3sp assertion failed");

// Next-cycle implication, live through reset.
`define H3SP_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("h3sp assertion failed");

`else

`define H3SP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define H3SP_ASSERT_NEXT(lbl, clk, ante, cons)

`endif

`endif

// File: rtl/core/h3sp_pkg.sv
// Types and constants shared by the settings body parser modules.
package h3sp_pkg;

   localparam int unsigned VAL_W = 62;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_TRUNCATED = 2'd1;
   localparam status_type ST_DUPLICATE = 2'd2;
   localparam status_type ST_RESERVED  = 2'd3;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       byte_valid;
      logic       end_of_body;
   } req_item_type;

   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] table_capacity;
      logic [VAL_W-1:0] blocked_streams;
      logic [VAL_W-1:0] field_section_limit;
      logic             connect_enabled;
      logic             settings_received;
   } rsp_item_type;

   // Item after the front has decoded the varint head fields of its byte.
   typedef struct packed {
      logic [7:0] body_byte;
      logic [5:0] head_bits;
      logic [2:0] head_left;
      logic       byte_valid;
      logic       end_of_body;
   } cls_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: rtl/core/h3sp_front.sv
// Front end: accepts body items, decodes varint head fields, feeds the queue.
module h3sp_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  h3sp_pkg::req_item_type req_item,
   input  h3sp_pkg::qstat_type   qstat,
   output logic                  push,
   output h3sp_pkg::cls_item_type push_item
);
   import h3sp_pkg::*;

   logic [2:0] left_by_len;

   always_comb begin
      unique case (req_item.body_byte[7:6])
         2'd0:    left_by_len = 3'd0;
         2'd1:    left_by_len = 3'd1;
         2'd2:    left_by_len = 3'd3;
         default: left_by_len = 3'd7;
      endcase
   end

   assign req_ready = !qstat.full;

   // Drop items that carry neither a byte nor an end mark.
   assign push = req_valid && req_ready && (req_item.byte_valid || req_item.end_of_body);

   always_comb begin
      push_item.body_byte   = req_item.body_byte;
      push_item.head_bits   = req_item.body_byte[5:0];
      push_item.head_left   = left_by_len;
      push_item.byte_valid  = req_item.byte_valid;
      push_item.end_of_body = req_item.end_of_body;
   end

endmodule

// File: rtl/core/h3sp_queue.sv
// Two-entry queue between the front end and the parser back end.
module h3sp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  h3sp_pkg::cls_item_type push_item,
   input  logic                   pop,
   output h3sp_pkg::cls_item_type head_item,
   output h3sp_pkg::qstat_type    qstat
);
   import h3sp_pkg::*;

   cls_item_type ent_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item   = ent_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == 2'd2);
   assign qstat.empty = (count_ff == 2'd0);

endmodule

// File: rtl/core/h3sp_back.sv
// Back end: varint assembly, setting bookkeeping and the result register.
module h3sp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  h3sp_pkg::qstat_type    qstat,
   input  h3sp_pkg::cls_item_type head_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output h3sp_pkg::rsp_item_type rsp_item
);
   import h3sp_pkg::*;

   typedef enum logic [2:0] {
      ID_OTHER,
      ID_CAPACITY,
      ID_BLOCKED,
      ID_SECTION,
      ID_CONNECT,
      ID_RESERVED
   } ident_kind_type;

   localparam logic [VAL_W-1:0] ID_CODE_CAPACITY = 62'h01;
   localparam logic [VAL_W-1:0] ID_CODE_BLOCKED  = 62'h07;
   localparam logic [VAL_W-1:0] ID_CODE_SECTION  = 62'h06;
   localparam logic [VAL_W-1:0] ID_CODE_CONNECT  = 62'h08;
   localparam logic [VAL_W-1:0] ID_CODE_RSV_A    = 62'h02;
   localparam logic [VAL_W-1:0] ID_CODE_RSV_B    = 62'h03;
   localparam logic [VAL_W-1:0] ID_CODE_RSV_C    = 62'h04;
   localparam logic [VAL_W-1:0] ID_CODE_RSV_D    = 62'h05;

   function automatic ident_kind_type classify_ident(input logic [VAL_W-1:0] v);
      ident_kind_type k;
      case (v) inside
         ID_CODE_CAPACITY: k = ID_CAPACITY;
         ID_CODE_BLOCKED:  k = ID_BLOCKED;
         ID_CODE_SECTION:  k = ID_SECTION;
         ID_CODE_CONNECT:  k = ID_CONNECT;
         ID_CODE_RSV_A, ID_CODE_RSV_B, ID_CODE_RSV_C, ID_CODE_RSV_D: k = ID_RESERVED;
         default:          k = ID_OTHER;
      endcase
      return k;
   endfunction

   logic [VAL_W-1:0] accum_ff, accum_in;
   logic [2:0]       left_ff, left_in;
   logic             phase_ff, phase_in;
   ident_kind_type   kind_ff, kind_in;
   logic [3:0]       seen_ff, seen_in;
   logic [VAL_W-1:0] cap_ff, cap_in;
   logic [VAL_W-1:0] blk_ff, blk_in;
   logic [VAL_W-1:0] sec_ff, sec_in;
   logic             con_ff, con_in;
   logic             err_ff, err_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic             err_hit;
   status_type       err_status;
   status_type       end_status;
   logic             has_result;
   logic             out_free;

   always_comb begin
      accum_in   = accum_ff;
      left_in    = left_ff;
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      seen_in    = seen_ff;
      cap_in     = cap_ff;
      blk_in     = blk_ff;
      sec_in     = sec_ff;
      con_in     = con_ff;
      err_hit    = 1'b0;
      err_status = ST_OK;

      if (head_item.byte_valid && !err_ff) begin
         if (left_ff == 3'd0) begin
            accum_in = {{(VAL_W-6){1'b0}}, head_item.head_bits};
            left_in  = head_item.head_left;
         end else begin
            accum_in = {accum_ff[VAL_W-9:0], head_item.body_byte};
            left_in  = left_ff - 3'd1;
         end
         if (left_in == 3'd0) begin
            if (!phase_ff) begin
               kind_in  = classify_ident(accum_in);
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               case (kind_ff)
                  ID_CAPACITY: begin
                     if (seen_ff[0]) begin
                        err_hit = 1'b1; err_status = ST_DUPLICATE;
                     end else begin
                        seen_in[0] = 1'b1; cap_in = accum_in;
                     end
                  end
                  ID_BLOCKED: begin
                     if (seen_ff[1]) begin
                        err_hit = 1'b1; err_status = ST_DUPLICATE;
                     end else begin
                        seen_in[1] = 1'b1; blk_in = accum_in;
                     end
                  end
                  ID_SECTION: begin
                     if (seen_ff[2]) begin
                        err_hit = 1'b1; err_status = ST_DUPLICATE;
                     end else begin
                        seen_in[2] = 1'b1; sec_in = accum_in;
                     end
                  end
                  ID_CONNECT: begin
                     if (seen_ff[3]) begin
                        err_hit = 1'b1; err_status = ST_DUPLICATE;
                     end else begin
                        seen_in[3] = 1'b1; con_in = (accum_in != '0);
                     end
                  end
                  ID_RESERVED: begin
                     err_hit = 1'b1; err_status = ST_RESERVED;
                  end
                  default: ;
               endcase
            end
         end
      end

      err_in     = err_ff || err_hit;
      has_result = err_hit || (head_item.end_of_body && !err_in);
      end_status = ((left_in != 3'd0) || phase_in) ? ST_TRUNCATED : ST_OK;

      rsp_item_in = '0;
      if (err_hit) begin
         rsp_item_in.status = err_status;
      end else begin
         rsp_item_in.status = end_status;
         if (end_status == ST_OK) begin
            rsp_item_in.table_capacity      = cap_in;
            rsp_item_in.blocked_streams     = blk_in;
            rsp_item_in.field_section_limit = sec_in;
            rsp_item_in.connect_enabled     = con_in;
            rsp_item_in.settings_received   = 1'b1;
         end
      end

      // End of body clears everything for the next body.
      if (head_item.end_of_body) begin
         accum_in = '0;
         left_in  = 3'd0;
         phase_in = 1'b0;
         kind_in  = ID_OTHER;
         seen_in  = 4'd0;
         cap_in   = '0;
         blk_in   = '0;
         sec_in   = '0;
         con_in   = 1'b0;
         err_in   = 1'b0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Items that give no result never wait on the output register.
   assign pop = !qstat.empty && (out_free || !has_result);

   always_comb begin
      if (pop && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         left_ff      <= 3'd0;
         phase_ff     <= 1'b0;
         kind_ff      <= ID_OTHER;
         seen_ff      <= 4'd0;
         cap_ff       <= '0;
         blk_ff       <= '0;
         sec_ff       <= '0;
         con_ff       <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            accum_ff <= accum_in;
            left_ff  <= left_in;
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            seen_ff  <= seen_in;
            cap_ff   <= cap_in;
            blk_ff   <= blk_in;
            sec_ff   <= sec_in;
            con_ff   <= con_in;
            err_ff   <= err_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && has_result) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: rtl/core/h3_settings_body_parser_core.sv
// Top level of the HTTP/3 settings frame body parser.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  h3sp_pkg::req_item_type
//   rsp_      out        rsp_valid / rsp_ready  h3sp_pkg::rsp_item_type
//
// One item per cycle sustained while the output is not stalled; a result is registered at
// the edge its item leaves the two-entry queue, so an accepted item passes a queue entry and then the output register.
// The output register holds one result; items without a result keep flowing
// while it stalls, and items that need it wait in the queue.
// Synchronous reset clears the queue, the body state and the output valid.
`include "h3_settings_body_parser_core_defines.svh"

module h3_settings_body_parser_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  h3sp_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output h3sp_pkg::rsp_item_type rsp_item
);
   import h3sp_pkg::*;

   qstat_type    qstat;
   logic         push;
   logic         pop;
   cls_item_type push_item;
   cls_item_type head_item;

   h3sp_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   h3sp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   h3sp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head_item (head_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   `H3SP_ASSERT_IMP(a_err_zero_fields, clock, reset,
      rsp_valid && (rsp_item.status != ST_OK),
      !rsp_item.settings_received && (rsp_item.table_capacity == '0) && !rsp_item.connect_enabled)
   `H3SP_ASSERT_IMP(a_received_is_ok, clock, reset,
      rsp_valid && rsp_item.settings_received, rsp_item.status == ST_OK)
   `H3SP_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, !qstat.empty)
   `H3SP_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid && !qstat.full)

endmodule
